[design/csl_pkg.sv]
// Package for the C subset lexer: item types, token codes, scan modes and
// character class and keyword lookup functions. No dependencies.
`timescale 1ns / 1ps
package csl_pkg;

  localparam int KEYWORD_MAX_CHARS_DEF = 8;
  localparam int POSITION_BITS_DEF     = 16;
  localparam int OFFSET_BITS_DEF       = 32;
  localparam int MAX_RES               = 3;
  localparam int QUEUE_DEPTH           = 4;
  localparam int QCNT_W                = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_KW                = 24;
  localparam logic [15:0] LEN_MAX      = 16'hFFFF;

  typedef enum logic [6:0] {
    TK_END = 7'd0, TK_KW_INT, TK_KW_CHAR, TK_KW_FLOAT, TK_KW_DOUBLE, TK_KW_VOID,
    TK_KW_LONG, TK_KW_SHORT, TK_KW_UNSIGNED, TK_KW_SIGNED, TK_KW_SIZE_T,
    TK_KW_BOOL, TK_KW_TRUE, TK_KW_FALSE, TK_KW_RETURN, TK_KW_IF, TK_KW_ELSE,
    TK_KW_WHILE, TK_KW_FOR, TK_KW_BREAK, TK_KW_CONTINUE, TK_KW_STRUCT,
    TK_KW_TYPEDEF, TK_KW_SIZEOF, TK_KW_NULL,
    TK_IDENT, TK_FLOAT_LIT, TK_NUMBER, TK_STRING, TK_UNKNOWN, TK_CHAR_LIT,
    TK_INC, TK_ADD_ASSIGN, TK_PLUS, TK_DEC, TK_SUB_ASSIGN, TK_ARROW, TK_MINUS,
    TK_MUL_ASSIGN, TK_STAR, TK_DIV_ASSIGN, TK_SLASH, TK_PERCENT, TK_EQ,
    TK_ASSIGN, TK_NE, TK_NOT, TK_LE, TK_SHL, TK_LT, TK_GE, TK_SHR, TK_GT,
    TK_LAND, TK_AMP, TK_LOR, TK_PIPE, TK_CARET, TK_TILDE, TK_LPAREN,
    TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_LBRACKET, TK_RBRACKET, TK_SEMI,
    TK_COMMA, TK_DOT, TK_COLON, TK_QUESTION, TK_PREPROC
  } tok_kind_e;

  typedef enum logic [4:0] {
    M_IDLE, M_SLASH, M_LINE_CMT, M_BLOCK_CMT, M_IDENT, M_NUMBER, M_NUM_DOT,
    M_FLOAT, M_STRING, M_CHARLIT, M_PREPROC, M_OP
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        comment_unclosed;
    logic        last_in_run;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] count;
  } push_t;

  // Keyword spellings, right aligned with zero padding in front.
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'("int"), 64'("char"), 64'("float"), 64'("double"), 64'("void"),
    64'("long"), 64'("short"), 64'("unsigned"), 64'("signed"), 64'("size_t"),
    64'("bool"), 64'("true"), 64'("false"), 64'("return"), 64'("if"),
    64'("else"), 64'("while"), 64'("for"), 64'("break"), 64'("continue"),
    64'("struct"), 64'("typedef"), 64'("sizeof"), 64'("NULL")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd4, 4'd5, 4'd8, 4'd6, 4'd6, 4'd4, 4'd4,
    4'd5, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6, 4'd7, 4'd6, 4'd4
  };

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [15:0] len_sat(logic [15:0] l);
    return (l < LEN_MAX) ? l + 16'd1 : l;
  endfunction

  // Second character of a two-character operator; TK_END means no pair.
  function automatic tok_kind_e op_pair(logic [7:0] f, logic [7:0] s);
    tok_kind_e k;
    k = TK_END;
    unique case (f)
      "+": k = (s == "+") ? TK_INC : (s == "=") ? TK_ADD_ASSIGN : TK_END;
      "-": k = (s == "-") ? TK_DEC : (s == "=") ? TK_SUB_ASSIGN :
               (s == ">") ? TK_ARROW : TK_END;
      "*": k = (s == "=") ? TK_MUL_ASSIGN : TK_END;
      "=": k = (s == "=") ? TK_EQ : TK_END;
      "!": k = (s == "=") ? TK_NE : TK_END;
      "<": k = (s == "=") ? TK_LE : (s == "<") ? TK_SHL : TK_END;
      ">": k = (s == "=") ? TK_GE : (s == ">") ? TK_SHR : TK_END;
      "&": k = (s == "&") ? TK_LAND : TK_END;
      "|": k = (s == "|") ? TK_LOR : TK_END;
      default: k = TK_END;
    endcase
    return k;
  endfunction

  function automatic tok_kind_e op_single(logic [7:0] f);
    tok_kind_e k;
    unique case (f)
      "+": k = TK_PLUS;
      "-": k = TK_MINUS;
      "*": k = TK_STAR;
      "=": k = TK_ASSIGN;
      "!": k = TK_NOT;
      "<": k = TK_LT;
      ">": k = TK_GT;
      "&": k = TK_AMP;
      default: k = TK_PIPE;
    endcase
    return k;
  endfunction

  function automatic tok_kind_e punct_kind(logic [7:0] c);
    tok_kind_e k;
    unique case (c)
      "%": k = TK_PERCENT;
      "^": k = TK_CARET;
      "~": k = TK_TILDE;
      "(": k = TK_LPAREN;
      ")": k = TK_RPAREN;
      "{": k = TK_LBRACE;
      "}": k = TK_RBRACE;
      "[": k = TK_LBRACKET;
      "]": k = TK_RBRACKET;
      ";": k = TK_SEMI;
      ",": k = TK_COMMA;
      ".": k = TK_DOT;
      ":": k = TK_COLON;
      "?": k = TK_QUESTION;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  // Packs the first len buffered characters right aligned and compares
  // against every keyword in parallel.
  function automatic tok_kind_e kw_lookup(logic [63:0] buf8, logic [15:0] len);
    logic [63:0] key;
    tok_kind_e   k;
    key = '0;
    k   = TK_IDENT;
    for (int i = 0; i < 8; i++) begin
      if (16'(i) < len) key = {key[55:0], buf8[8*i +: 8]};
    end
    for (int j = 0; j < NUM_KW; j++) begin
      if (len == 16'(KW_LEN[j]) && key == KW_TEXT[j]) k = tok_kind_e'(7'(j + 1));
    end
    return k;
  endfunction

  function automatic out_item_t mk_tok(tok_kind_e k, logic [31:0] ln, logic [31:0] cl,
                                       logic [63:0] off, logic [15:0] len, logic unc);
    out_item_t t;
    t.token_kind       = k;
    t.start_line       = ln[15:0];
    t.start_col        = cl[15:0];
    t.start_offset     = off[31:0];
    t.token_length     = len;
    t.comment_unclosed = unc;
    t.last_in_run      = 1'b0;
    return t;
  endfunction

endpackage

[design/csl_queue.sv]
// Result queue for the C subset lexer: takes up to three tokens per cycle
// and hands them out one per cycle unless stalled. Depends on csl_pkg.
`timescale 1ns / 1ps
module csl_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csl_pkg::push_t      push_i,
  input  csl_pkg::out_item_t  push_data_i [csl_pkg::MAX_RES],
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csl_pkg::out_item_t  out_data_o
);
  import csl_pkg::*;

  out_item_t          q_q [QUEUE_DEPTH];
  out_item_t          q_d [QUEUE_DEPTH];
  logic [QCNT_W-1:0]  cnt_q, cnt_d, base;
  logic               pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = q_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign base        = cnt_q - QCNT_W'(pop);
  // Room must remain for the largest burst one request can cause.
  assign full_o      = (base > QCNT_W'(QUEUE_DEPTH - MAX_RES));

  // Shift out the head, then append the new tokens behind the survivors.
  always_comb begin
    logic [QCNT_W-1:0] rel;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rel    = QCNT_W'(i) - base;
      q_d[i] = (pop && i < QUEUE_DEPTH - 1) ? q_q[(i + 1) % QUEUE_DEPTH] : q_q[i];
      if (push_i.valid && QCNT_W'(i) >= base && rel < QCNT_W'(push_i.count)) begin
        q_d[i] = push_data_i[rel[1:0]];
      end
    end
    cnt_d = base + (push_i.valid ? QCNT_W'(push_i.count) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

[design/c_subset_lexer.sv]
// Top level of the C subset lexer: scan state, token assembly and the
// result queue. Depends on csl_pkg and csl_queue.
`timescale 1ns / 1ps
// Streaming lexer for a subset of C. One source byte, or an end mark, is taken
// per cycle; each request is lexed in the cycle it is accepted and the tokens it
// completes (zero to three) go into a four-entry result queue that delivers one
// token per cycle unless stalled. Input stalls only while the queue cannot take
// a three-token burst, so runs of back-to-back single-character tokens beyond
// output bandwidth stall. A token is reported on its last byte if that byte
// closes it, else on the next byte or at the end mark, which also reports the
// end token with the unclosed-comment flag. No reset sweep is needed.
module c_subset_lexer #(
  parameter int KEYWORD_MAX_CHARS = csl_pkg::KEYWORD_MAX_CHARS_DEF,
  parameter int POSITION_BITS     = csl_pkg::POSITION_BITS_DEF,
  parameter int OFFSET_BITS       = csl_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csl_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csl_pkg::out_item_t  out_data_o
);
  import csl_pkg::*;

  localparam int WIW = $clog2(KEYWORD_MAX_CHARS);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  scan_mode_e               mode_q, mode_d;
  logic [7:0]               pend_q, pend_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
  logic [POSITION_BITS-1:0] tline_q, tline_d, tcol_q, tcol_d, dcol_q, dcol_d;
  logic [OFFSET_BITS-1:0]   off_q, off_d, toff_q, toff_d;
  logic [15:0]              tlen_q, tlen_d;
  logic                     esc_q, esc_d, star_q, star_d;
  logic [7:0]               wbuf_q [KEYWORD_MAX_CHARS];
  logic [7:0]               wbuf_d [KEYWORD_MAX_CHARS];

  out_item_t res [MAX_RES];
  logic [1:0] nres;
  logic       accept, full;
  push_t      push;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Lex one request: state update and the tokens it completes, in order.
  always_comb begin
    logic [7:0]  c;
    logic        eos, do_flush, do_idle, unc;
    logic [63:0] buf8;
    tok_kind_e   k;
    c        = in_data_i.src_byte;
    eos      = in_data_i.end_of_source;
    do_flush = 1'b0;
    do_idle  = 1'b0;
    unc      = 1'b0;
    buf8     = '0;
    k        = TK_END;
    mode_d = mode_q; pend_d = pend_q; line_d = line_q; col_d = col_q;
    off_d = off_q; tline_d = tline_q; tcol_d = tcol_q; toff_d = toff_q;
    tlen_d = tlen_q; esc_d = esc_q; star_d = star_q; dcol_d = dcol_q;
    wbuf_d = wbuf_q;
    nres = 2'd0;
    for (int i = 0; i < MAX_RES; i++) res[i] = '0;
    for (int i = 0; i < 8; i++) buf8[8*i +: 8] = wbuf_q[i];

    if (eos) begin
      unc      = (mode_q == M_BLOCK_CMT);
      do_flush = 1'b1;
    end else begin
      unique case (mode_q)
        M_SLASH: begin
          if (c == "/") mode_d = M_LINE_CMT;
          else if (c == "*") begin
            mode_d = M_BLOCK_CMT;
            star_d = 1'b0;
          end else if (c == "=") begin
            tlen_d = 16'd2;
            res[0] = mk_tok(TK_DIV_ASSIGN, 32'(tline_q), 32'(tcol_q), 64'(toff_q),
                            16'd2, 1'b0);
            nres   = 2'd1;
            mode_d = M_IDLE;
          end else begin
            do_flush = 1'b1; do_idle = 1'b1;
          end
        end
        M_LINE_CMT: if (c == 8'h0A) mode_d = M_IDLE;
        M_BLOCK_CMT: begin
          if (star_q && c == "/") begin
            mode_d = M_IDLE;
            star_d = 1'b0;
          end else star_d = (c == "*");
        end
        M_IDENT: begin
          if (is_ident(c)) begin
            if (tlen_q < 16'(KEYWORD_MAX_CHARS)) wbuf_d[tlen_q[WIW-1:0]] = c;
            tlen_d = len_sat(tlen_q);
          end else begin
            do_flush = 1'b1; do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) tlen_d = len_sat(tlen_q);
          else if (c == ".") begin
            dcol_d = col_q;
            mode_d = M_NUM_DOT;
          end else begin
            do_flush = 1'b1; do_idle = 1'b1;
          end
        end
        M_NUM_DOT: begin
          if (is_digit(c)) begin
            tlen_d = len_sat(len_sat(tlen_q));
            mode_d = M_FLOAT;
          end else begin
            do_flush = 1'b1; do_idle = 1'b1;
          end
        end
        M_FLOAT: begin
          if (is_digit(c)) tlen_d = len_sat(tlen_q);
          else begin
            do_flush = 1'b1; do_idle = 1'b1;
          end
        end
        M_STRING, M_CHARLIT: begin
          priority if (esc_q) begin
            esc_d  = 1'b0;
            tlen_d = len_sat(tlen_q);
          end else if (c == 8'h5C) begin
            esc_d  = 1'b1;
            tlen_d = len_sat(tlen_q);
          end else if (mode_q == M_STRING && c == 8'h22) begin
            tlen_d = len_sat(tlen_q);
            res[0] = mk_tok(TK_STRING, 32'(tline_q), 32'(tcol_q), 64'(toff_q),
                            tlen_d, 1'b0);
            nres   = 2'd1;
            mode_d = M_IDLE;
          end else if (mode_q == M_CHARLIT && c == 8'h27) begin
            tlen_d = len_sat(tlen_q);
            res[0] = mk_tok(TK_CHAR_LIT, 32'(tline_q), 32'(tcol_q), 64'(toff_q),
                            tlen_d, 1'b0);
            nres   = 2'd1;
            mode_d = M_IDLE;
          end else if (mode_q == M_CHARLIT && c == 8'h0A) begin
            do_flush = 1'b1; do_idle = 1'b1;
          end else tlen_d = len_sat(tlen_q);
        end
        M_PREPROC: begin
          if (c == 8'h0A) begin
            do_flush = 1'b1; do_idle = 1'b1;
          end else tlen_d = len_sat(tlen_q);
        end
        M_OP: begin
          k = op_pair(pend_q, c);
          if (k != TK_END) begin
            tlen_d = 16'd2;
            res[0] = mk_tok(k, 32'(tline_q), 32'(tcol_q), 64'(toff_q), 16'd2, 1'b0);
            nres   = 2'd1;
            mode_d = M_IDLE;
          end else begin
            do_flush = 1'b1; do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
    end

    // Report the token held in the old mode.
    if (do_flush) begin
      unique case (mode_q)
        M_SLASH:   k = TK_SLASH;
        M_IDENT:   k = (tlen_q > 16'(KEYWORD_MAX_CHARS)) ? TK_IDENT
                                                         : kw_lookup(buf8, tlen_q);
        M_NUMBER, M_NUM_DOT: k = TK_NUMBER;
        M_FLOAT:   k = TK_FLOAT_LIT;
        M_STRING, M_CHARLIT: k = TK_UNKNOWN;
        M_PREPROC: k = TK_PREPROC;
        M_OP:      k = op_single(pend_q);
        default:   k = TK_END;
      endcase
      if (k != TK_END) begin
        res[nres] = mk_tok(k, 32'(tline_q), 32'(tcol_q), 64'(toff_q), tlen_q, 1'b0);
        nres      = nres + 2'd1;
      end
      // A dot that found no digit after it becomes a token of its own.
      if (mode_q == M_NUM_DOT) begin
        res[nres] = mk_tok(TK_DOT, 32'(line_q), 32'(dcol_q),
                           64'(off_q - OFFSET_BITS'(1)), 16'd1, 1'b0);
        nres      = nres + 2'd1;
      end
      mode_d = M_IDLE;
    end

    // Lex the byte from the idle state.
    if (do_idle) begin
      mode_d = M_IDLE;
      if (!is_space(c)) begin
        if (c == "/" || is_alpha(c) || c == "_" || is_digit(c) || c == 8'h22 ||
            c == 8'h27 || c == "#" || op_pair(c, "=") != TK_END || c == "&" ||
            c == "|") begin
          tline_d = line_q;
          tcol_d  = col_q;
          toff_d  = off_q;
          tlen_d  = 16'd1;
          priority if (c == "/") mode_d = M_SLASH;
          else if (is_alpha(c) || c == "_") begin
            mode_d    = M_IDENT;
            wbuf_d[0] = c;
          end else if (is_digit(c)) mode_d = M_NUMBER;
          else if (c == 8'h22) begin
            mode_d = M_STRING;
            esc_d  = 1'b0;
          end else if (c == 8'h27) begin
            mode_d = M_CHARLIT;
            esc_d  = 1'b0;
          end else if (c == "#") mode_d = M_PREPROC;
          else begin
            mode_d = M_OP;
            pend_d = c;
          end
        end else begin
          res[nres] = mk_tok(punct_kind(c), 32'(line_q), 32'(col_q), 64'(off_q),
                             16'd1, 1'b0);
          nres      = nres + 2'd1;
        end
      end
    end

    if (eos) begin
      esc_d     = 1'b0;
      star_d    = 1'b0;
      mode_d    = M_IDLE;
      res[nres] = mk_tok(TK_END, 32'(line_q), 32'(col_q), 64'(off_q), 16'd0, unc);
      nres      = nres + 2'd1;
    end else begin
      // Advance the source position.
      off_d = off_q + OFFSET_BITS'(1);
      if (c == 8'h0A) begin
        if (line_q < POS_MAX) line_d = line_q + POSITION_BITS'(1);
        col_d = POSITION_BITS'(1);
      end else if (col_q < POS_MAX) begin
        col_d = col_q + POSITION_BITS'(1);
      end
    end

    if (nres != 2'd0) res[nres - 2'd1].last_in_run = 1'b1;
  end

  assign push.valid = accept && (nres != 2'd0);
  assign push.count = nres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pend_q  <= '0;
      line_q  <= POSITION_BITS'(1);
      col_q   <= POSITION_BITS'(1);
      off_q   <= '0;
      tline_q <= POSITION_BITS'(1);
      tcol_q  <= POSITION_BITS'(1);
      toff_q  <= '0;
      tlen_q  <= '0;
      esc_q   <= 1'b0;
      star_q  <= 1'b0;
      dcol_q  <= POSITION_BITS'(1);
    end else if (accept) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      line_q  <= line_d;
      col_q   <= col_d;
      off_q   <= off_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      toff_q  <= toff_d;
      tlen_q  <= tlen_d;
      esc_q   <= esc_d;
      star_q  <= star_d;
      dcol_q  <= dcol_d;
    end
  end

  // Identifier prefix buffer; entries are only read after being written.
  always_ff @(posedge clk_i) begin
    if (accept) wbuf_q <= wbuf_d;
  end

  csl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
